// ----- hw/rtl/page_frame_free_list_allocator_defines.svh -----
// assertion macros used by the bound checker (pffl_checker)
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PFFL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pffl check failed");

// next-cycle implication
`define PFFL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pffl check failed");

`endif

// ----- hw/rtl/pffl_pkg.sv -----
`default_nettype none
package pffl_pkg;

	localparam int FRAMES_DEF  = 1024;
	localparam int MAX_RUN_DEF = 64;
	localparam int FRAME_W     = 10;
	localparam int CNT_W       = 7;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_GRANT   = 2'd0,
		STAT_DONE    = 2'd1,
		STAT_REFUSED = 2'd2
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [FRAME_W-1:0]  frame;
		logic                last;
	} res_t;

	typedef enum logic [3:0] {
		ST_INIT = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_RD   = 4'b0100,
		ST_WB   = 4'b1000
	} state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pffl_ram.sv -----
`default_nettype none
module pffl_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/pffl_out_stage.sv -----
`default_nettype none
module pffl_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  pffl_pkg::res_t                res,
	output logic                          room,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [pffl_pkg::FRAME_W-1:0]  granted_frame,
	output logic                          last
);
	import pffl_pkg::*;

	logic valid_q;
	res_t res_q;

	assign room = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid     = valid_q;
	assign status        = res_q.status;
	assign granted_frame = res_q.frame;
	assign last          = res_q.last;

endmodule
`default_nettype wire

// ----- hw/rtl/page_frame_free_list_allocator.sv -----
// channel   direction   handshake               payload
// in        into block  in_valid / in_ready     cmd, count, frame
// out       from block  out_valid / out_ready   status, granted_frame, last
//
// after reset the next-frame memory is swept once, with in_ready low
// free and any single-result request: result registered, valid in the cycle after acceptance
// allocate of n frames: each granted frame takes a memory read, then a head write-back
// a stalled output holds the walk in the write-back step (or in the read step once the list has run out);
// in_ready needs the output slot; reset: asynchronous, active low; the memory contents are rebuilt by the sweep
`default_nettype none
module page_frame_free_list_allocator #(
	parameter int FRAMES  = pffl_pkg::FRAMES_DEF,
	parameter int MAX_RUN = pffl_pkg::MAX_RUN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [pffl_pkg::CNT_W-1:0]    count,
	input  logic [pffl_pkg::FRAME_W-1:0]  frame,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [pffl_pkg::FRAME_W-1:0]  granted_frame,
	output logic                          last
);
	import pffl_pkg::*;

	localparam int PW = $clog2(FRAMES + 1);
	localparam int AW = $clog2(FRAMES);
	localparam logic [PW-1:0] NULL_PTR = PW'(FRAMES);
	localparam logic [PW-1:0] LAST_IDX = PW'(FRAMES - 1);

	state_t           state_q;
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    free_q;
	logic [PW-1:0]    init_q;
	logic [CNT_W-1:0] remain_q;

	logic             room;
	logic             accept;
	logic             free_ok;
	logic             alloc_bad;
	logic             head_null;
	logic             res_load;
	res_t             res_d;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [PW-1:0]    mem_wdata;
	logic             mem_re;
	logic [PW-1:0]    mem_rdata;

	assign in_ready  = (state_q == ST_IDLE) && room;
	assign accept    = in_valid && in_ready;
	assign free_ok   = (32'(frame) < FRAMES) && (32'(free_q) < FRAMES);
	assign alloc_bad = (32'(count) > 32'(free_q)) || (32'(count) > MAX_RUN);
	assign head_null = (head_q == NULL_PTR);

	always_comb begin
		res_load  = 1'b0;
		res_d     = '{status: STAT_DONE, frame: '0, last: 1'b1};
		mem_we    = 1'b0;
		mem_waddr = init_q[AW-1:0];
		mem_wdata = init_q + PW'(1);
		mem_re    = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_FREE) begin
						res_load = 1'b1;
						if (free_ok) begin
							mem_we    = 1'b1;
							mem_waddr = AW'(frame);
							mem_wdata = head_q;
						end else begin
							res_d.status = STAT_REFUSED;
						end
					end else if (alloc_bad) begin
						res_load     = 1'b1;
						res_d.status = STAT_REFUSED;
					end else if (count == '0) begin
						res_load = 1'b1;
					end
				end
			end
			ST_RD: begin
				if (head_null) begin
					res_load     = room;
					res_d.status = STAT_REFUSED;
				end else begin
					mem_re = 1'b1;
				end
			end
			ST_WB: begin
				res_load     = room;
				res_d.status = STAT_GRANT;
				res_d.frame  = FRAME_W'(head_q);
				res_d.last   = (remain_q == CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			head_q   <= '0;
			free_q   <= NULL_PTR;
			init_q   <= '0;
			remain_q <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + PW'(1);
					if (init_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_FREE) begin
							if (free_ok) begin
								head_q <= PW'(frame);
								free_q <= free_q + PW'(1);
							end
						end else if (!alloc_bad && count != '0) begin
							remain_q <= count;
							state_q  <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (head_null) begin
						if (room) begin
							free_q  <= '0;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (room) begin
						head_q   <= mem_rdata;
						free_q   <= free_q - PW'(1);
						remain_q <= remain_q - CNT_W'(1);
						state_q  <= (remain_q == CNT_W'(1)) ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	pffl_ram #(
		.WIDTH (PW),
		.DEPTH (FRAMES)
	) u_next_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (head_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	pffl_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (res_load),
		.res           (res_d),
		.room          (room),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_frame (granted_frame),
		.last          (last)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/pffl_checker.sv -----
`default_nettype none
`include "page_frame_free_list_allocator_defines.svh"
module pffl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    status,
	input logic [pffl_pkg::FRAME_W-1:0]  granted_frame,
	input logic                          last
);
	import pffl_pkg::*;

	// a new transaction is only taken when the output slot can take its result
	`PFFL_ASSERT_IMP(a_in_needs_slot, in_ready, !out_valid || out_ready)

	// only grants carry a frame, everything else closes the request
	`PFFL_ASSERT_IMP(a_nongrant_last, out_valid && status != STAT_GRANT,
		last && granted_frame == '0)

	`PFFL_ASSERT_IMP(a_status_code, out_valid,
		status == STAT_GRANT || status == STAT_DONE || status == STAT_REFUSED)

	// stalled result holds
	`PFFL_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(granted_frame) && $stable(last))

endmodule

bind page_frame_free_list_allocator pffl_checker u_pffl_checker (.*);
`default_nettype wire

// ----- tb/pffl_checker.sv -----
`timescale 1ns / 1ps
module tb_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          cmd,
	input  logic [pffl_pkg::CNT_W-1:0]    count,
	input  logic [pffl_pkg::FRAME_W-1:0]  frame,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [1:0]                    status,
	input  logic [pffl_pkg::FRAME_W-1:0]  granted_frame,
	input  logic                          last,
	output int                            fails,
	output int                            pending
);
	import pffl_pkg::*;

	localparam int FRAMES     = FRAMES_DEF;
	localparam int MAX_RUN    = MAX_RUN_DEF;
	localparam int NULL_FRAME = FRAMES;

	logic [10:0] next_frame [FRAMES];
	logic [10:0] head_frame;
	logic [10:0] free_frames;
	res_t        replies [$];

	task automatic push_reply(input status_t s, input logic [FRAME_W-1:0] f, input logic l);
		res_t r;
		r.status = s;
		r.frame  = f;
		r.last   = l;
		replies.insert(replies.size(), r);
	endtask

	// one accepted transaction: update the free list and queue its replies
	task automatic apply_request(input logic c, input logic [CNT_W-1:0] n,
			input logic [FRAME_W-1:0] f);
		logic [10:0] g;
		int          i;
		if (c == CMD_FREE) begin
			if (f >= FRAMES || free_frames >= FRAMES) begin
				push_reply(STAT_REFUSED, '0, 1'b1);
			end else begin
				next_frame[f] = head_frame;
				head_frame = {1'b0, f};
				free_frames = free_frames + 11'd1;
				push_reply(STAT_DONE, '0, 1'b1);
			end
		end else if (n > free_frames || n > MAX_RUN) begin
			push_reply(STAT_REFUSED, '0, 1'b1);
		end else if (n == 0) begin
			push_reply(STAT_DONE, '0, 1'b1);
		end else begin
			for (i = 0; i < n; i++) begin
				// list ran out before the count did
				if (head_frame >= NULL_FRAME) begin
					free_frames = '0;
					push_reply(STAT_REFUSED, '0, 1'b1);
					break;
				end
				g = head_frame;
				head_frame = next_frame[g[FRAME_W-1:0]];
				if (head_frame > NULL_FRAME)
					head_frame = 11'(NULL_FRAME);
				free_frames = free_frames - 11'd1;
				push_reply(STAT_GRANT, g[FRAME_W-1:0], i == n - 1);
			end
		end
	endtask

	task automatic check_reply();
		res_t e;
		if (replies.size() == 0) begin
			$error("unexpected transaction: status %0d granted_frame %0d last %0d",
				status, granted_frame, last);
			fails++;
		end else begin
			e = replies.pop_front();
			if (status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, status);
				fails++;
			end
			if (granted_frame !== e.frame) begin
				$error("granted_frame: expected %0d, actual %0d", e.frame, granted_frame);
				fails++;
			end
			if (last !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, last);
				fails++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++)
				next_frame[i] = 11'(i + 1);
			head_frame = '0;
			free_frames = 11'(FRAMES);
			replies.delete();
			fails = 0;
		end else begin
			if (in_valid && in_ready)
				apply_request(cmd, count, frame);
			if (out_valid && out_ready)
				check_reply();
		end
		pending = replies.size();
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import pffl_pkg::*;

	localparam int PERIOD       = 12;
	localparam int PHASE_ITEMS  = 120;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam int TIMEOUT_NS   = 12_000_000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               cmd = CMD_ALLOC;
	logic [CNT_W-1:0]   count = '0;
	logic [FRAME_W-1:0] frame = '0;
	logic               out_ready = 1'b0;
	logic               in_ready;
	logic               out_valid;
	logic [1:0]         status;
	logic [FRAME_W-1:0] granted_frame;
	logic               last;
	int                 fails;
	int                 pending;

	logic [FRAME_W-1:0] held_frames [$];
	int                 idle_pct = 0;
	int                 stall_pct = 0;
	int                 hold_token = 0;
	int                 hold_seen = 0;
	int                 hold_left = 0;

	always #(PERIOD / 2) clk = ~clk;

	page_frame_free_list_allocator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.count         (count),
		.frame         (frame),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_frame (granted_frame),
		.last          (last)
	);

	tb_checker CHK (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.count         (count),
		.frame         (frame),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_frame (granted_frame),
		.last          (last),
		.fails         (fails),
		.pending       (pending)
	);

	// frames handed out, to be given back later
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready && status == STAT_GRANT)
			held_frames.insert(held_frames.size(), granted_frame);
	end

	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// entered at a falling edge, returns at the falling edge after acceptance
	task automatic offer(input logic c, input logic [CNT_W-1:0] n,
			input logic [FRAME_W-1:0] f);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		count <= n;
		frame <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic release_frame(input logic [FRAME_W-1:0] f);
		for (int i = 0; i < held_frames.size(); i++) begin
			if (held_frames[i] == f) begin
				held_frames.delete(i);
				break;
			end
		end
		offer(CMD_FREE, CNT_W'($urandom_range(0, 127)), f);
	endtask

	task automatic set_phase(input int p);
		in_valid <= 1'b0;
		@(posedge clk);
		case (p)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 62;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 62;
				hold_token++;
			end
			default: begin
				idle_pct = 34;
				stall_pct = 34;
			end
		endcase
		@(negedge clk);
	endtask

	task automatic random_request(input bit noisy);
		int                 r;
		int                 idx;
		logic [CNT_W-1:0]   n;
		logic [FRAME_W-1:0] f;
		r = $urandom_range(0, 99);
		n = CNT_W'($urandom_range(0, 127));
		f = FRAME_W'($urandom_range(0, 1023));
		if (noisy && r < 8) begin
			// stray free, may hit a frame already on the list
			offer(CMD_FREE, n, f);
		end else if (held_frames.size() > 0 && r < 55) begin
			idx = $urandom_range(0, held_frames.size() - 1);
			f = held_frames[idx];
			held_frames.delete(idx);
			offer(CMD_FREE, n, f);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70)
				n = CNT_W'($urandom_range(1, 8));
			else if (r < 82)
				n = CNT_W'($urandom_range(0, MAX_RUN_DEF));
			else if (r < 88)
				n = CNT_W'(MAX_RUN_DEF);
			else if (r < 93)
				n = '0;
			else
				n = CNT_W'($urandom_range(MAX_RUN_DEF + 1, 127));
			offer(CMD_ALLOC, n, f);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// free while every frame is free, empty and oversized runs
		offer(CMD_FREE, 7'd0, 10'd5);
		offer(CMD_ALLOC, 7'd0, 10'd1023);
		offer(CMD_ALLOC, 7'd65, FRAME_W'($urandom_range(0, 1023)));
		offer(CMD_ALLOC, 7'd127, FRAME_W'($urandom_range(0, 1023)));
		// take the whole list in maximal runs, then ask an empty list
		repeat (16)
			offer(CMD_ALLOC, CNT_W'(MAX_RUN_DEF), FRAME_W'($urandom_range(0, 1023)));
		offer(CMD_ALLOC, 7'd1, FRAME_W'($urandom_range(0, 1023)));
		offer(CMD_ALLOC, 7'd0, FRAME_W'($urandom_range(0, 1023)));
		drain();
		release_frame(10'd0);
		release_frame(10'd1023);
		offer(CMD_ALLOC, 7'd2, 10'd0);

		for (int p = 0; p < 4; p++) begin
			set_phase(p);
			for (int k = 0; k < PHASE_ITEMS; k++)
				random_request(p == 3);
			if (p == 1)
				drain();
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("PASS page_frame_free_list_allocator");
		else
			$display("FAIL page_frame_free_list_allocator");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL page_frame_free_list_allocator");
		$finish;
	end

endmodule
